@@ rtl/core/pllts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pllts_pkg
// Shared depths, entry types and status codes of the landing/takeoff
// scheduler.
// ----------------------------------------------------------------------------
package pllts_pkg;

  // Store depths
  localparam int unsigned LANDING_DEPTH = 16;
  localparam int unsigned TAKEOFF_DEPTH = 16;

  localparam int unsigned LCNT_W = $clog2(LANDING_DEPTH + 1);
  localparam int unsigned LIDX_W = $clog2(LANDING_DEPTH);
  localparam int unsigned TCNT_W = $clog2(TAKEOFF_DEPTH + 1);
  localparam int unsigned TIDX_W = $clog2(TAKEOFF_DEPTH);

  // Result status codes
  localparam logic [2:0] ST_LANDED  = 3'd0;
  localparam logic [2:0] ST_TOOKOFF = 3'd1;
  localparam logic [2:0] ST_NONE    = 3'd2;
  localparam logic [2:0] ST_ACCEPT  = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  // Landing entry, ordered by severity then arrival stamp
  typedef struct packed {
    logic [15:0] arrival_time;
    logic [3:0]  severity;
    logic [15:0] flight_id;
  } land_entry_t;

  // Takeoff entry
  typedef struct packed {
    logic [3:0]  severity;
    logic [15:0] flight_id;
  } tko_entry_t;

endpackage

@@ rtl/core/pllts_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pllts_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pllts_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/pllts_rank.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pllts_rank
// Shared compare unit: tells whether entry a is served before entry b.
// ----------------------------------------------------------------------------
module pllts_rank (
  input  pllts_pkg::land_entry_t a_i,
  input  pllts_pkg::land_entry_t b_i,
  output logic                   outranks_o
);

  import pllts_pkg::*;

  // Higher severity first, earlier arrival breaks ties
  always_comb begin
    if (a_i.severity != b_i.severity) begin
      outranks_o = a_i.severity > b_i.severity;
    end else begin
      outranks_o = a_i.arrival_time < b_i.arrival_time;
    end
  end

endmodule

@@ rtl/core/priority_landing_lifo_takeoff_scheduler.sv @@
`timescale 1ns / 1ps
// A request passes through the dispatch state, then the insertion walk, the
// head read and shift, or the stack pop as needed, and the done state, which
// loads the output register. Only one request is in flight; the input is ready
// again once the result sits in the output register. Reset clears both counts,
// the sequencer and the output valid; RAM contents stay undefined until written.
// ----------------------------------------------------------------------------
// priority_landing_lifo_takeoff_scheduler
// Sorted landing queue and takeoff stack with strict landing priority.
// ----------------------------------------------------------------------------
module priority_landing_lifo_takeoff_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] flight_id, [19:16] severity, [35:20] arrival_time, [39:36] zero
  input  logic [39:0] s_axis_tdata,
  // [0] req_type, [1] is_takeoff
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] out_flight_id, [19:16] out_severity, [23:20] zero
  output logic [23:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]  m_axis_tuser
);

  import pllts_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_INS   = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_HEAD  = 3'd4;
  localparam logic [2:0] S_SHIFT = 3'd5;
  localparam logic [2:0] S_POP   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [LCNT_W-1:0] lcount_q, lcount_d;
  logic [TCNT_W-1:0] tcount_q, tcount_d;
  logic [LCNT_W-1:0] pos_q, pos_d;
  land_entry_t       req_q, req_d;
  logic              req_srv_q, req_srv_d;
  logic              req_tko_q, req_tko_d;
  logic [2:0]        res_status_q, res_status_d;
  logic [15:0]       res_id_q, res_id_d;
  logic [3:0]        res_sev_q, res_sev_d;
  logic              m_valid_q, m_valid_d;
  logic [23:0]       m_data_q, m_data_d;
  logic [2:0]        m_user_q, m_user_d;

  logic              in_fire;
  logic              out_load;
  logic              outranks;
  land_entry_t       in_entry;

  logic              l_we;
  logic [LCNT_W-1:0] l_waddr_full;
  logic [LCNT_W-1:0] l_raddr_full;
  land_entry_t       l_wdata;
  land_entry_t       l_rdata;
  logic              t_we;
  logic [TCNT_W-1:0] t_raddr_full;
  tko_entry_t        t_wdata;
  tko_entry_t        t_rdata;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_entry      = land_entry_t'(s_axis_tdata[35:0]);
  assign t_wdata       = '{severity: req_q.severity, flight_id: req_q.flight_id};

  // Landing store
  pllts_ram #(
    .WIDTH ($bits(land_entry_t)),
    .DEPTH (LANDING_DEPTH)
  ) u_land_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr_full[LIDX_W-1:0]),
    .wdata_i (l_wdata),
    .raddr_i (l_raddr_full[LIDX_W-1:0]),
    .rdata_o (l_rdata)
  );

  // Takeoff stack
  pllts_ram #(
    .WIDTH ($bits(tko_entry_t)),
    .DEPTH (TAKEOFF_DEPTH)
  ) u_tko_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (tcount_q[TIDX_W-1:0]),
    .wdata_i (t_wdata),
    .raddr_i (t_raddr_full[TIDX_W-1:0]),
    .rdata_o (t_rdata)
  );

  // Shared compare unit for the insertion walk
  pllts_rank u_rank (
    .a_i        (req_q),
    .b_i        (l_rdata),
    .outranks_o (outranks)
  );

  // Sequencer
  always_comb begin
    state_d      = state_q;
    lcount_d     = lcount_q;
    tcount_d     = tcount_q;
    pos_d        = pos_q;
    req_d        = req_q;
    req_srv_d    = req_srv_q;
    req_tko_d    = req_tko_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_sev_d    = res_sev_q;
    l_we         = 1'b0;
    l_waddr_full = pos_q;
    l_wdata      = req_q;
    l_raddr_full = '0;
    t_we         = 1'b0;
    t_raddr_full = tcount_q - TCNT_W'(1);
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          req_d     = in_entry;
          req_srv_d = s_axis_tuser[0];
          req_tko_d = s_axis_tuser[1];
          state_d   = S_DISP;
        end
      end

      S_DISP: begin
        res_id_d  = '0;
        res_sev_d = '0;
        state_d   = S_DONE;
        if (!req_srv_q) begin
          if (req_tko_q) begin
            // Push onto the stack unless full
            if (tcount_q == TCNT_W'(TAKEOFF_DEPTH)) begin
              res_status_d = ST_FULL;
            end else begin
              t_we         = 1'b1;
              tcount_d     = tcount_q + TCNT_W'(1);
              res_status_d = ST_ACCEPT;
            end
          end else if (lcount_q == LCNT_W'(LANDING_DEPTH)) begin
            res_status_d = ST_FULL;
          end else begin
            res_status_d = ST_ACCEPT;
            lcount_d     = lcount_q + LCNT_W'(1);
            if (lcount_q == '0) begin
              l_we         = 1'b1;
              l_waddr_full = '0;
            end else begin
              // Start the walk from the tail
              l_raddr_full = lcount_q - LCNT_W'(1);
              pos_d        = lcount_q;
              state_d      = S_INS;
            end
          end
        end else if (lcount_q != '0) begin
          res_status_d = ST_LANDED;
          l_raddr_full = '0;
          state_d      = S_HEAD;
        end else if (tcount_q != '0) begin
          res_status_d = ST_TOOKOFF;
          state_d      = S_POP;
        end else begin
          res_status_d = ST_NONE;
        end
      end

      S_INS: begin
        l_we = 1'b1;
        if (outranks) begin
          // Move the stored entry up one slot and keep walking
          l_wdata = l_rdata;
          pos_d   = pos_q - LCNT_W'(1);
          if (pos_q > LCNT_W'(1)) begin
            l_raddr_full = pos_q - LCNT_W'(2);
          end else begin
            state_d = S_PUT;
          end
        end else begin
          state_d = S_DONE;
        end
      end

      S_PUT: begin
        l_we    = 1'b1;
        state_d = S_DONE;
      end

      S_HEAD: begin
        res_id_d  = l_rdata.flight_id;
        res_sev_d = l_rdata.severity;
        if (lcount_q > LCNT_W'(1)) begin
          l_raddr_full = LCNT_W'(1);
          pos_d        = '0;
          state_d      = S_SHIFT;
        end else begin
          lcount_d = lcount_q - LCNT_W'(1);
          state_d  = S_DONE;
        end
      end

      S_SHIFT: begin
        // Close the gap left by the served head
        l_we    = 1'b1;
        l_wdata = l_rdata;
        if ((pos_q + LCNT_W'(2)) < lcount_q) begin
          l_raddr_full = pos_q + LCNT_W'(2);
          pos_d        = pos_q + LCNT_W'(1);
        end else begin
          lcount_d = lcount_q - LCNT_W'(1);
          state_d  = S_DONE;
        end
      end

      S_POP: begin
        res_id_d  = t_rdata.flight_id;
        res_sev_d = t_rdata.severity;
        tcount_d  = tcount_q - TCNT_W'(1);
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    if (out_load) begin
      m_valid_d = 1'b1;
      m_data_d  = {4'b0, res_sev_q, res_id_q};
      m_user_d  = res_status_q;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      lcount_q  <= '0;
      tcount_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      lcount_q  <= lcount_d;
      tcount_q  <= tcount_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    req_q        <= req_d;
    req_srv_q    <= req_srv_d;
    req_tko_q    <= req_tko_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_sev_q    <= res_sev_d;
    m_data_q     <= m_data_d;
    m_user_q     <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`ifndef SYNTHESIS
  // Input closes for the cycle after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> !s_axis_tready)
    else $error("input ready right after a transfer");

  // A new result only appears from the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_DONE))
    else $error("output valid rose outside the done state");

  // Counts never exceed the store depths
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lcount_q <= LCNT_W'(LANDING_DEPTH)) && (tcount_q <= TCNT_W'(TAKEOFF_DEPTH)))
    else $error("store count beyond depth");

  // A full drop only happens when the addressed store is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && res_status_q == ST_FULL) |->
      (req_tko_q ? (tcount_q == TCNT_W'(TAKEOFF_DEPTH))
                 : (lcount_q == LCNT_W'(LANDING_DEPTH))))
    else $error("add dropped while space was free");
`endif

endmodule

@@ sim/tb_priority_landing_lifo_takeoff_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_landing_lifo_takeoff_scheduler
// Self-checking bench for the landing/takeoff scheduler. A clocked driver
// feeds requests from a queue, and each accepted transfer is run through an
// in-bench model of the sorted landing store and the takeoff stack. A clocked
// monitor compares every result transfer with the oldest predicted outcome.
// The stimulus has a directed opening and then random bursts that fill,
// drain and mix, under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_priority_landing_lifo_takeoff_scheduler;
  import pllts_pkg::*;

  // Request kinds carried in tuser bit 0
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_SERVE = 1'b1;

  // Burst shapes of the random part
  localparam int MODE_MIX       = 0;
  localparam int MODE_FILL_LAND = 1;
  localparam int MODE_FILL_TKO  = 2;
  localparam int MODE_DRAIN     = 3;

  localparam int PHASE_ITEMS = 156;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = LANDING_DEPTH + 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic        req_type;
    logic        is_takeoff;
    logic [15:0] flight_id;
    logic [3:0]  severity;
    logic [15:0] arrival_time;
    bit          sync;  // wait until every outcome is back before offering
  } sched_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] flight_id;
    logic [3:0]  severity;
  } sched_res_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  // Bench model state
  land_entry_t land_q [LANDING_DEPTH];
  int unsigned land_cnt = 0;
  tko_entry_t  tko_stk [TAKEOFF_DEPTH];
  int unsigned tko_cnt = 0;

  sched_req_t  request_q [$];
  sched_res_t  dispatch_log [$];
  sched_req_t  live_req;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_go = 1'b0;
  int hold_left = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int err_count = 0;
  int cycle_cnt = 0;
  int total_reqs = 0;
  int n_landed = 0;
  int n_tookoff = 0;
  int n_none = 0;
  int n_accept = 0;
  int n_full = 0;

  priority_landing_lifo_takeoff_scheduler uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one request to the model and return the outcome it must produce
  function automatic sched_res_t dispatch_request(sched_req_t r);
    sched_res_t  res;
    land_entry_t e;
    int          pos;
    res = '{status: ST_ACCEPT, flight_id: 16'd0, severity: 4'd0};
    if (r.req_type == REQ_ADD) begin
      if (r.is_takeoff) begin
        if (tko_cnt >= TAKEOFF_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          tko_stk[tko_cnt] = tko_entry_t'{severity: r.severity, flight_id: r.flight_id};
          tko_cnt++;
        end
      end else if (land_cnt >= LANDING_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        e = land_entry_t'{arrival_time: r.arrival_time, severity: r.severity,
                          flight_id: r.flight_id};
        pos = land_cnt;
        // Shift lower-ranked entries down; equal keys keep arrival order
        while (pos > 0 && (e.severity > land_q[pos-1].severity ||
               (e.severity == land_q[pos-1].severity &&
                e.arrival_time < land_q[pos-1].arrival_time))) begin
          land_q[pos] = land_q[pos-1];
          pos--;
        end
        land_q[pos] = e;
        land_cnt++;
      end
    end else if (land_cnt > 0) begin
      res = '{status: ST_LANDED, flight_id: land_q[0].flight_id,
              severity: land_q[0].severity};
      for (int i = 0; i + 1 < land_cnt; i++) land_q[i] = land_q[i+1];
      land_cnt--;
    end else if (tko_cnt > 0) begin
      tko_cnt--;
      res = '{status: ST_TOOKOFF, flight_id: tko_stk[tko_cnt].flight_id,
              severity: tko_stk[tko_cnt].severity};
    end else begin
      res.status = ST_NONE;
    end
    return res;
  endfunction

  function automatic sched_req_t mk_req(logic kind, logic tko, logic [15:0] id,
                                        logic [3:0] sev, logic [15:0] arr);
    sched_req_t r;
    r = '{req_type: kind, is_takeoff: tko, flight_id: id, severity: sev,
          arrival_time: arr, sync: 1'b0};
    return r;
  endfunction

  function automatic sched_req_t random_req(int mode);
    sched_req_t r;
    r = mk_req(REQ_ADD, 1'b0, 16'($urandom_range(16'hFFFF)), 4'($urandom_range(15)),
               16'($urandom_range(16'hFFFF)));
    // Narrow keys now and then so ties in severity and arrival show up
    if ($urandom_range(99) < (mode == MODE_FILL_LAND ? 35 : 10)) begin
      r.severity     = 4'($urandom_range(1) ? 15 : $urandom_range(5, 6));
      r.arrival_time = 16'($urandom_range(3));
    end
    case (mode)
      MODE_MIX: begin
        r.req_type   = ($urandom_range(99) < 45) ? REQ_SERVE : REQ_ADD;
        r.is_takeoff = 1'($urandom_range(1));
      end
      MODE_FILL_TKO: begin
        r.is_takeoff = 1'b1;
      end
      MODE_DRAIN: begin
        r.req_type   = REQ_SERVE;
        r.is_takeoff = 1'($urandom_range(1));
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_cnt);
    err_count++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (request_q.size() != 0 || s_axis_tvalid || n_accepted != n_checked);
  endtask

  // Queue random bursts for one idling pattern, then let them all complete
  task automatic run_phase(int idle_pct, int stall_pct, int n_items, bit with_hold);
    int mode;
    int len;
    int pick;
    sched_req_t r;
    @(negedge clk_i);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (n_items > 0) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        mode = MODE_MIX;
        len  = $urandom_range(8, 24);
      end else if (pick < 60) begin
        mode = MODE_FILL_LAND;
        len  = $urandom_range(14, 20);
      end else if (pick < 75) begin
        mode = MODE_FILL_TKO;
        len  = $urandom_range(14, 20);
      end else begin
        mode = MODE_DRAIN;
        len  = $urandom_range(10, 36);
      end
      for (int i = 0; i < len; i++) begin
        r = random_req(mode);
        r.sync = (i == 0) && ($urandom_range(5) == 0);
        request_q.push_back(r);
      end
      n_items    -= len;
      total_reqs += len;
    end
    // Stall the receiver for a long stretch while the sender keeps offering
    if (with_hold) begin
      hold_go = 1'b1;
      @(negedge clk_i);
      hold_go = 1'b0;
    end
    wait_drained();
  endtask

  // Drive requests; hold the offered transfer until it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    bit took;
    bit can_go;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      took = s_axis_tvalid && s_axis_tready;
      if (took) begin
        dispatch_log.push_back(dispatch_request(live_req));
        n_accepted <= n_accepted + 1;
      end
      if (!s_axis_tvalid || took) begin
        can_go = request_q.size() != 0 && $urandom_range(99) >= send_idle_pct;
        if (can_go && request_q[0].sync && (n_accepted + int'(took)) != n_checked)
          can_go = 1'b0;
        if (can_go) begin
          live_req = request_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, live_req.arrival_time, live_req.severity,
                            live_req.flight_id};
          s_axis_tuser  <= {live_req.is_takeoff, live_req.req_type};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Count down the receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Check each result transfer against the oldest predicted outcome
  always @(posedge clk_i or negedge rst_ni) begin
    sched_res_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_checked <= n_checked + 1;
        case (m_axis_tuser)
          ST_LANDED:  n_landed++;
          ST_TOOKOFF: n_tookoff++;
          ST_NONE:    n_none++;
          ST_ACCEPT:  n_accept++;
          ST_FULL:    n_full++;
          default:    ;
        endcase
        if (dispatch_log.size() == 0) begin
          report_mismatch("result with nothing outstanding", m_axis_tuser, 0);
        end else begin
          want = dispatch_log.pop_front();
          if (m_axis_tuser !== want.status)
            report_mismatch("status", m_axis_tuser, want.status);
          if (m_axis_tdata[15:0] !== want.flight_id)
            report_mismatch("flight_id", m_axis_tdata[15:0], want.flight_id);
          if (m_axis_tdata[19:16] !== want.severity)
            report_mismatch("severity", m_axis_tdata[19:16], want.severity);
        end
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Abort a run that stops making progress
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding",
               cycle_cnt, n_accepted - n_checked);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening: empty serve, stack order, sort order with ties, extremes
    request_q.push_back(mk_req(REQ_SERVE, 1'b0, 16'h0000, 4'h0, 16'h0000));
    request_q.push_back(mk_req(REQ_ADD,   1'b1, 16'hFFFF, 4'hF, 16'h0000));
    request_q.push_back(mk_req(REQ_ADD,   1'b1, 16'h0000, 4'h0, 16'h0000));
    request_q.push_back(mk_req(REQ_SERVE, 1'b0, 16'h0000, 4'h0, 16'h0000));
    request_q.push_back(mk_req(REQ_ADD,   1'b0, 16'h0001, 4'h0, 16'hFFFF));
    request_q.push_back(mk_req(REQ_ADD,   1'b0, 16'h0002, 4'hF, 16'h0000));
    request_q.push_back(mk_req(REQ_ADD,   1'b0, 16'h0003, 4'hF, 16'h0000));
    request_q.push_back(mk_req(REQ_ADD,   1'b0, 16'hFFFF, 4'h7, 16'h8000));
    request_q.push_back(mk_req(REQ_ADD,   1'b0, 16'h0005, 4'hF, 16'hFFFF));
    repeat (6) request_q.push_back(mk_req(REQ_SERVE, 1'b0, 16'h0000, 4'h0, 16'h0000));
    request_q.push_back(mk_req(REQ_SERVE, 1'b0, 16'hFFFF, 4'hF, 16'hFFFF));
    request_q.push_back(mk_req(REQ_SERVE, 1'b1, 16'hAAAA, 4'h5, 16'h5555));
    request_q.push_back(mk_req(REQ_ADD,   1'b1, 16'h1234, 4'h9, 16'hFFFF));
    request_q.push_back(mk_req(REQ_ADD,   1'b0, 16'h0000, 4'h0, 16'h0000));
    request_q.push_back(mk_req(REQ_SERVE, 1'b0, 16'h0000, 4'h0, 16'h0000));
    request_q.push_back(mk_req(REQ_SERVE, 1'b1, 16'h0000, 4'h0, 16'h0000));
    total_reqs = request_q.size();
    wait_drained();

    run_phase(0, 0, PHASE_ITEMS, 1'b0);
    run_phase(62, 0, PHASE_ITEMS, 1'b0);
    run_phase(0, 62, PHASE_ITEMS, 1'b0);
    run_phase(28, 28, PHASE_ITEMS, 1'b0);
    run_phase(0, 0, PHASE_ITEMS, 1'b1);

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (dispatch_log.size() != 0)
      report_mismatch("outcomes never delivered", 0, dispatch_log.size());

    $display("Covered %0d requests: %0d landings, %0d takeoffs, %0d empty serves,",
             total_reqs, n_landed, n_tookoff, n_none);
    $display("  %0d accepted adds, %0d full drops; %0d mismatches in %0d cycles",
             n_accept, n_full, err_count, cycle_cnt);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
